[rtl/trss_pkg.sv]
// package for the thread ready and sleep scheduler
// request, status and source codes, fsm state type; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package trss_pkg;
    localparam int THREAD_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int ID_W = 4;
    localparam int TICK_W = 32;

    typedef enum logic [1:0] {
        REQ_PUSH_NEW   = 2'd0,
        REQ_PUSH_WAIT  = 2'd1,
        REQ_PUSH_SLEEP = 2'd2,
        REQ_SCHEDULE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NONE     = 2'd1,
        ST_REJECTED = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FROM_NONE  = 2'd0,
        FROM_NEW   = 2'd1,
        FROM_SLEEP = 2'd2,
        FROM_WAIT  = 2'd3
    } from_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_NEW   = 2'd1,
        MEM_WAIT  = 2'd2,
        MEM_SLEEP = 2'd3
    } member_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK_RD,
        S_WALK_CMP,
        S_RESULT
    } state_t;
endpackage
`default_nettype wire

[rtl/trss_mem.sv]
// thread slot store: link and wake time memory, one write and one read port,
// registered read data; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module trss_mem #(
    parameter int SLOTS = 16,
    parameter int TW = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
    input  wire logic                     wr_link_en,
    input  wire logic [$clog2(SLOTS)-1:0] wr_link,
    input  wire logic                     wr_wake_en,
    input  wire logic [TW-1:0]            wr_wake,
    input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic      [$clog2(SLOTS)-1:0] rd_link,
    output logic      [TW-1:0]            rd_wake
);
    localparam int IW = $clog2(SLOTS);
    logic [IW-1:0] link_mem [SLOTS];
    logic [TW-1:0] wake_mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en && wr_link_en) begin
            link_mem[wr_addr] <= wr_link;
        end
        if (wr_en && wr_wake_en) begin
            wake_mem[wr_addr] <= wr_wake;
        end
        rd_link <= link_mem[rd_addr];
        rd_wake <= wake_mem[rd_addr];
    end
endmodule
`default_nettype wire

[rtl/thread_ready_and_sleep_scheduler.sv]
// top level: request fsm over the slot store, queue heads and tails, membership
// depends on trss_pkg and trss_mem
//
//  channel   | dir | tdata fields (low bit up)                               | tuser
//  s_axis_*  | in  | thread_id[3:0], sleep_ticks[35:4], current_tick[67:36] | req_type
//  m_axis_*  | out | status[1:0], picked_thread[5:2], picked_from[7:6]      | none
//
// a push new/waiting or a schedule passes decide, walk_rd and result after accept,
// plus walk_cmp when the pick comes from waiting; a rejected push or a first sleeper goes from decide to result.
// a push sleeping compares one sleeper per cycle in walk_cmp;
// the registered read data of the slot store sets this pace.
// one request is worked at a time; s_axis_tready is high only in idle.
// a stalled result holds until taken; reset clears all queues at once.
`timescale 1ns / 1ps
`default_nettype none
module thread_ready_and_sleep_scheduler #(
    parameter int THREAD_SLOTS = trss_pkg::THREAD_SLOTS_DEF,
    parameter int TIME_BITS = trss_pkg::TIME_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // thread_id, sleep_ticks, current_tick, 4 zero bits
    input  wire logic [71:0] s_axis_tdata,
    // req_type
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status, picked_thread, picked_from
    output logic [7:0]       m_axis_tdata
);
    localparam int IW = $clog2(THREAD_SLOTS);
    localparam int QW = IW + 1;
    localparam logic [QW-1:0] EMPTY = QW'(THREAD_SLOTS);

    trss_pkg::state_t state_reg, state_next;
    logic [QW-1:0] head_reg [3];
    logic [QW-1:0] head_next [3];
    logic [QW-1:0] tail_reg [3];
    logic [QW-1:0] tail_next [3];
    logic [1:0] member_reg [THREAD_SLOTS];
    logic [1:0] member_next [THREAD_SLOTS];

    logic [1:0] req_reg, req_next;
    logic [trss_pkg::ID_W-1:0] tid_reg, tid_next;
    logic [TIME_BITS-1:0] now_reg, now_next, wake_reg, wake_next;
    logic [IW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic have_prev_reg, have_prev_next;
    logic [7:0] out_reg, out_next;

    logic wr_en, wr_link_en, wr_wake_en;
    logic [IW-1:0] wr_addr, wr_link, rd_addr, rd_link;
    logic [TIME_BITS-1:0] wr_wake, rd_wake;

    trss_mem #(.SLOTS(THREAD_SLOTS), .TW(TIME_BITS)) u_mem (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_link_en(wr_link_en),
        .wr_link(wr_link), .wr_wake_en(wr_wake_en), .wr_wake(wr_wake),
        .rd_addr(rd_addr), .rd_link(rd_link), .rd_wake(rd_wake)
    );

    logic [TIME_BITS-1:0] in_now, in_sum;
    logic [trss_pkg::ID_W-1:0] in_tid;
    assign in_tid = s_axis_tdata[3:0];
    assign in_now = TIME_BITS'(s_axis_tdata[67:36]);
    assign in_sum = TIME_BITS'(s_axis_tdata[35:4]) + in_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= trss_pkg::S_IDLE;
            for (int i = 0; i < 3; i++) begin
                head_reg[i] <= EMPTY;
                tail_reg[i] <= EMPTY;
            end
            for (int i = 0; i < THREAD_SLOTS; i++) begin
                member_reg[i] <= trss_pkg::MEM_NONE;
            end
        end else begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            member_reg <= member_next;
        end
        req_reg <= req_next;
        tid_reg <= tid_next;
        now_reg <= now_next;
        wake_reg <= wake_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        have_prev_reg <= have_prev_next;
        out_reg <= out_next;
    end

    logic [1:0] q;
    logic [IW-1:0] t;
    logic in_range;
    logic [QW-1:0] hs;

    always_comb begin
        state_next = state_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        member_next = member_reg;
        req_next = req_reg;
        tid_next = tid_reg;
        now_next = now_reg;
        wake_next = wake_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        have_prev_next = have_prev_reg;
        out_next = out_reg;
        wr_en = 1'b0;
        wr_link_en = 1'b0;
        wr_wake_en = 1'b0;
        wr_addr = cur_reg;
        wr_link = cur_reg;
        wr_wake = wake_reg;
        rd_addr = cur_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        q = 2'd0;
        t = IW'(tid_reg);
        in_range = ({28'd0, tid_reg} < 32'(THREAD_SLOTS));
        hs = head_reg[2];
        case (state_reg)
            trss_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    req_next = s_axis_tuser;
                    tid_next = in_tid;
                    now_next = in_now;
                    wake_next = in_sum;
                    state_next = trss_pkg::S_DECIDE;
                end
                // prefetch the new queue head for a schedule
                rd_addr = IW'(head_reg[0]);
            end
            trss_pkg::S_DECIDE: begin
                // first pass: for a schedule, read the new head, or the sleeping head if new is empty
                out_next = {trss_pkg::FROM_NONE, 4'd0, trss_pkg::ST_OK};
                if (req_reg == trss_pkg::REQ_SCHEDULE) begin
                    if (head_reg[0] != EMPTY) begin
                        q = 2'd0;
                        out_next = {trss_pkg::FROM_NEW, 4'(head_reg[0]), trss_pkg::ST_OK};
                    end else begin
                        q = 2'd2;
                        out_next = {trss_pkg::FROM_SLEEP, 4'(hs), trss_pkg::ST_OK};
                    end
                    rd_addr = IW'(q == 2'd0 ? head_reg[0] : hs);
                    cur_next = rd_addr;
                    have_prev_next = 1'b0;
                    state_next = trss_pkg::S_WALK_RD;
                end else if (!in_range || member_reg[t] != trss_pkg::MEM_NONE) begin
                    out_next = {trss_pkg::FROM_NONE, 4'd0, trss_pkg::ST_REJECTED};
                    state_next = trss_pkg::S_RESULT;
                end else if (req_reg != trss_pkg::REQ_PUSH_SLEEP) begin
                    q = req_reg;
                    wr_en = 1'b1;
                    wr_link_en = 1'b1;
                    wr_addr = t;
                    wr_link = t;
                    if (head_reg[q] == EMPTY) begin
                        head_next[q] = QW'(t);
                    end
                    tail_next[q] = QW'(t);
                    member_next[t] = (q == 2'd0) ? trss_pkg::MEM_NEW : trss_pkg::MEM_WAIT;
                    state_next = trss_pkg::S_WALK_RD;
                    cur_next = IW'(tail_reg[q]);
                    have_prev_next = (head_reg[q] != EMPTY);
                end else begin
                    wr_en = 1'b1;
                    wr_link_en = 1'b1;
                    wr_wake_en = 1'b1;
                    wr_addr = t;
                    wr_link = t;
                    member_next[t] = trss_pkg::MEM_SLEEP;
                    if (hs == EMPTY) begin
                        head_next[2] = QW'(t);
                        tail_next[2] = QW'(t);
                        state_next = trss_pkg::S_RESULT;
                    end else begin
                        cur_next = IW'(hs);
                        have_prev_next = 1'b0;
                        state_next = trss_pkg::S_WALK_CMP;
                        rd_addr = IW'(hs);
                    end
                end
            end
            trss_pkg::S_WALK_RD: begin
                if (req_reg == trss_pkg::REQ_SCHEDULE) begin
                    // rd data holds the chosen head entry
                    if (head_reg[0] != EMPTY) begin
                        q = 2'd0;
                    end else if (hs != EMPTY && rd_wake <= now_reg) begin
                        q = 2'd2;
                    end else begin
                        q = 2'd1;
                        out_next = {trss_pkg::FROM_WAIT, 4'(head_reg[1]), trss_pkg::ST_OK};
                    end
                    if (q == 2'd1 && head_reg[1] == EMPTY) begin
                        out_next = {trss_pkg::FROM_NONE, 4'd0, trss_pkg::ST_NONE};
                        state_next = trss_pkg::S_RESULT;
                    end else if (q == 2'd1) begin
                        // waiting head link must be read first
                        req_next = trss_pkg::REQ_PUSH_NEW;
                        cur_next = IW'(head_reg[1]);
                        rd_addr = IW'(head_reg[1]);
                        state_next = trss_pkg::S_WALK_CMP;
                    end else begin
                        member_next[IW'(head_reg[q])] = trss_pkg::MEM_NONE;
                        if (head_reg[q] == tail_reg[q]) begin
                            head_next[q] = EMPTY;
                            tail_next[q] = EMPTY;
                        end else begin
                            head_next[q] = QW'(rd_link);
                        end
                        state_next = trss_pkg::S_RESULT;
                    end
                end else begin
                    // fifo push: link old tail to the new thread
                    if (have_prev_reg) begin
                        wr_en = 1'b1;
                        wr_link_en = 1'b1;
                        wr_addr = cur_reg;
                        wr_link = t;
                    end
                    state_next = trss_pkg::S_RESULT;
                end
            end
            trss_pkg::S_WALK_CMP: begin
                if (req_reg == trss_pkg::REQ_PUSH_NEW) begin
                    // deferred pop of the waiting head
                    member_next[cur_reg] = trss_pkg::MEM_NONE;
                    if (head_reg[1] == tail_reg[1]) begin
                        head_next[1] = EMPTY;
                        tail_next[1] = EMPTY;
                    end else begin
                        head_next[1] = QW'(rd_link);
                    end
                    state_next = trss_pkg::S_RESULT;
                end else if (rd_wake > wake_reg) begin
                    wr_en = 1'b1;
                    wr_link_en = 1'b1;
                    wr_addr = t;
                    wr_link = cur_reg;
                    if (have_prev_reg) begin
                        // link the previous sleeper to the new one in the next cycle
                        req_next = trss_pkg::REQ_PUSH_WAIT;
                        state_next = trss_pkg::S_WALK_RD;
                        have_prev_next = 1'b1;
                        cur_next = prev_reg;
                    end else begin
                        head_next[2] = QW'(t);
                        state_next = trss_pkg::S_RESULT;
                    end
                end else if (QW'(cur_reg) == tail_reg[2]) begin
                    wr_en = 1'b1;
                    wr_link_en = 1'b1;
                    wr_addr = cur_reg;
                    wr_link = t;
                    tail_next[2] = QW'(t);
                    state_next = trss_pkg::S_RESULT;
                end else begin
                    prev_next = cur_reg;
                    have_prev_next = 1'b1;
                    cur_next = rd_link;
                    rd_addr = rd_link;
                    state_next = trss_pkg::S_WALK_CMP;
                end
            end
            trss_pkg::S_RESULT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    state_next = trss_pkg::S_IDLE;
                end
            end
            default: state_next = trss_pkg::S_IDLE;
        endcase
    end

    assign m_axis_tdata = out_reg;

    // a result is never offered while a request can be accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("result and accept overlap");
    // head and tail of the new and sleep queues are both empty or both set
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg[0] == EMPTY) == (tail_reg[0] == EMPTY))
        else $error("new queue head/tail mismatch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg[2] == EMPTY) == (tail_reg[2] == EMPTY))
        else $error("sleep queue head/tail mismatch");
    // an accepted request reaches the decision step next
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> state_reg == trss_pkg::S_DECIDE)
        else $error("accept did not start work");
endmodule
`default_nettype wire

[sim/tb_thread_ready_and_sleep_scheduler.sv]
// testbench for the thread ready and sleep scheduler: directed and random requests
// checked beat by beat against a behavioral queue predictor; depends on trss_pkg and the top level
`timescale 1ns / 1ps
module tb_thread_ready_and_sleep_scheduler;
    localparam int SLOTS = 16;
    localparam logic [4:0] NO_SLOT = 5'd16;
    localparam int QI_NEW = 0;
    localparam int QI_WAIT = 1;
    localparam int QI_SLEEP = 2;

    // field order matches m_axis_tdata: picked_from high, status low
    typedef struct packed {
        trss_pkg::from_t   from;
        logic [3:0]        thread;
        trss_pkg::status_t status;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    always #4 aclk = ~aclk;

    thread_ready_and_sleep_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor copy of the scheduler state
    logic [3:0]        succ [SLOTS];
    logic [31:0]       wake [SLOTS];
    trss_pkg::member_t owner [SLOTS];
    logic [4:0]        head [3];
    logic [4:0]        tail [3];

    answer_t answers_due[$];
    int      fails = 0;
    int      hold_cycles = 0;
    int      rx_wait = 0;
    int      acc_done = 0;

    function automatic logic [3:0] dequeue(int q);
        logic [3:0] t;
        t = head[q][3:0];
        if (head[q] == tail[q]) begin
            head[q] = NO_SLOT;
            tail[q] = NO_SLOT;
        end else begin
            head[q] = {1'b0, succ[t]};
        end
        owner[t] = trss_pkg::MEM_NONE;
        return t;
    endfunction

    function automatic void enqueue(int q, logic [3:0] t);
        if (head[q] == NO_SLOT) head[q] = {1'b0, t};
        else succ[tail[q][3:0]] = t;
        tail[q] = {1'b0, t};
        succ[t] = t;
    endfunction

    // sleepers with equal wake time keep arrival order
    function automatic void sleep_link(logic [3:0] t, logic [31:0] w);
        logic [3:0] cur, prev;
        bit have_prev;
        have_prev = 0;
        wake[t] = w;
        succ[t] = t;
        if (head[QI_SLEEP] == NO_SLOT) begin
            head[QI_SLEEP] = {1'b0, t};
            tail[QI_SLEEP] = {1'b0, t};
            return;
        end
        cur = head[QI_SLEEP][3:0];
        prev = cur;
        for (int i = 0; i < SLOTS; i++) begin
            if (wake[cur] > w) begin
                succ[t] = cur;
                if (have_prev) succ[prev] = t;
                else head[QI_SLEEP] = {1'b0, t};
                return;
            end
            if ({1'b0, cur} == tail[QI_SLEEP]) break;
            prev = cur;
            have_prev = 1;
            cur = succ[cur];
        end
        succ[tail[QI_SLEEP][3:0]] = t;
        tail[QI_SLEEP] = {1'b0, t};
    endfunction

    function automatic answer_t schedule_outcome(trss_pkg::req_t req, logic [3:0] tid,
                                                 logic [31:0] ticks, logic [31:0] now);
        answer_t a;
        a = '{trss_pkg::FROM_NONE, 4'd0, trss_pkg::ST_OK};
        if (req == trss_pkg::REQ_SCHEDULE) begin
            if (head[QI_NEW] != NO_SLOT) begin
                a.thread = dequeue(QI_NEW);
                a.from = trss_pkg::FROM_NEW;
            end else if (head[QI_SLEEP] != NO_SLOT && wake[head[QI_SLEEP][3:0]] <= now) begin
                a.thread = dequeue(QI_SLEEP);
                a.from = trss_pkg::FROM_SLEEP;
            end else if (head[QI_WAIT] != NO_SLOT) begin
                a.thread = dequeue(QI_WAIT);
                a.from = trss_pkg::FROM_WAIT;
            end else begin
                a.status = trss_pkg::ST_NONE;
            end
        end else if (owner[tid] != trss_pkg::MEM_NONE) begin
            a.status = trss_pkg::ST_REJECTED;
        end else if (req == trss_pkg::REQ_PUSH_NEW) begin
            enqueue(QI_NEW, tid);
            owner[tid] = trss_pkg::MEM_NEW;
        end else if (req == trss_pkg::REQ_PUSH_WAIT) begin
            enqueue(QI_WAIT, tid);
            owner[tid] = trss_pkg::MEM_WAIT;
        end else begin
            sleep_link(tid, now + ticks);
            owner[tid] = trss_pkg::MEM_SLEEP;
        end
        return a;
    endfunction

    task automatic send_request(trss_pkg::req_t req, logic [3:0] tid, logic [31:0] ticks,
                                logic [31:0] now);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {4'd0, now, ticks, tid};
        do @(posedge aclk); while (!s_axis_tready);
        answers_due.push_back(schedule_outcome(req, tid, ticks, now));
        acc_done++;
    endtask

    // result side: a drawn wait after each beat, plus a long hold when requested
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) rx_wait = $urandom_range(0, 10);
            else if (rx_wait > 0) rx_wait = rx_wait - 1;
            m_axis_tready <= (rx_wait == 0);
        end
    end

    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (answers_due.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                fails++;
            end else begin
                want = answers_due.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fails++;
                end
                if (got.thread !== want.thread) begin
                    $error("picked_thread: expected %0d, got %0d", want.thread, got.thread);
                    fails++;
                end
                if (got.from !== want.from) begin
                    $error("picked_from: expected %0d, got %0d", want.from, got.from);
                    fails++;
                end
            end
        end
    end

    task automatic test_directed();
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'd0);
        send_request(trss_pkg::REQ_PUSH_NEW, 4'd0, 32'd0, 32'd5);
        send_request(trss_pkg::REQ_PUSH_NEW, 4'd0, 32'd0, 32'd5);
        send_request(trss_pkg::REQ_PUSH_WAIT, 4'd15, 32'd0, 32'd5);
        send_request(trss_pkg::REQ_PUSH_SLEEP, 4'd15, 32'd1, 32'd5);
        send_request(trss_pkg::REQ_PUSH_SLEEP, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(trss_pkg::REQ_PUSH_SLEEP, 4'd4, 32'd10, 32'd100);
        send_request(trss_pkg::REQ_PUSH_SLEEP, 4'd5, 32'd10, 32'd100);
        send_request(trss_pkg::REQ_PUSH_SLEEP, 4'd6, 32'd0, 32'd50);
        send_request(trss_pkg::REQ_PUSH_SLEEP, 4'd7, 32'hFFFF_FFFF, 32'd0);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd9, 32'd0, 32'd0);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'd49);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'd110);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'd110);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'd110);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'd110);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'd0);
    endtask

    task automatic test_random(int count);
        logic [31:0] now, ticks;
        int r;
        now = $urandom;
        for (int i = 0; i < count; i++) begin
            now = now + $urandom_range(0, 40);
            r = $urandom_range(0, 9);
            ticks = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 120);
            if ($urandom_range(0, 30) == 0) now = $urandom;
            if (r < 4) send_request(trss_pkg::REQ_SCHEDULE, 4'($urandom), $urandom, now);
            else if (r < 5) send_request(trss_pkg::REQ_PUSH_NEW, 4'($urandom), $urandom, now);
            else if (r < 6) send_request(trss_pkg::REQ_PUSH_WAIT, 4'($urandom), $urandom, now);
            else send_request(trss_pkg::REQ_PUSH_SLEEP, 4'($urandom), ticks, now);
        end
    endtask

    task automatic test_output_stall();
        hold_cycles = 300;
        for (int i = 0; i < 16; i++)
            send_request(trss_pkg::REQ_PUSH_SLEEP, 4'(i), $urandom_range(0, 5), 32'd0);
        for (int i = 0; i < 16; i++)
            send_request(trss_pkg::REQ_SCHEDULE, 4'd0, 32'd0, 32'd10);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) owner[i] = trss_pkg::MEM_NONE;
        for (int q = 0; q < 3; q++) begin
            head[q] = NO_SLOT;
            tail[q] = NO_SLOT;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_output_stall();
        test_random(2000);
        drain();
        if (fails == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
